[rtl/sfd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg
// Types and constants shared by the serial frame deframer modules.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam logic [7:0] HeadFirstReset  = 8'd170;
  localparam logic [7:0] HeadSecondReset = 8'd85;
  localparam logic [7:0] TailFirstReset  = 8'd13;
  localparam logic [7:0] TailSecondReset = 8'd10;

  typedef enum logic [1:0] {
    CFG_HEAD_FIRST  = 2'd0,
    CFG_HEAD_SECOND = 2'd1,
    CFG_TAIL_FIRST  = 2'd2,
    CFG_TAIL_SECOND = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_HEAD1   = 4'd1,
    PH_TASK_HI = 4'd2,
    PH_TASK_LO = 4'd3,
    PH_LENGTH  = 4'd4,
    PH_PAYLOAD = 4'd5,
    PH_CHECK   = 4'd6,
    PH_TAIL1   = 4'd7,
    PH_TAIL2   = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2,
    KIND_ABORT   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] head_first;
    logic [7:0] head_second;
    logic [7:0] tail_first;
    logic [7:0] tail_second;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [15:0] job_id;
    logic [7:0]  payload_length;
  } res_t;

endpackage
`default_nettype wire

[rtl/sfd_cfg_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_cfg_regs
// Header and trailer match registers behind a simple write port.
// ----------------------------------------------------------------------------
module sfd_cfg_regs (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [7:0]   cfg_data_i,
  output sfd_pkg::cfg_t     cfg_o
);
  import sfd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_HEAD_FIRST:  cfg_d.head_first  = cfg_data_i;
        CFG_HEAD_SECOND: cfg_d.head_second = cfg_data_i;
        CFG_TAIL_FIRST:  cfg_d.tail_first  = cfg_data_i;
        CFG_TAIL_SECOND: cfg_d.tail_second = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_first  <= HeadFirstReset;
      cfg_q.head_second <= HeadSecondReset;
      cfg_q.tail_first  <= TailFirstReset;
      cfg_q.tail_second <= TailSecondReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

[rtl/sfd_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_parser
// Frame state machine with running XOR; one byte per step, at most one result.
// ----------------------------------------------------------------------------
module sfd_parser (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         step_i,
  input  wire logic [7:0]   byte_i,
  input  wire sfd_pkg::cfg_t cfg_i,
  output logic              res_valid_o,
  output sfd_pkg::res_t     res_o
);
  import sfd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  xor_q, xor_d;
  logic [15:0] task_q, task_d;
  logic [7:0]  len_q, len_d;
  logic        ok_q, ok_d;

  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    count_d = count_q;
    xor_d   = xor_q;
    task_d  = task_q;
    len_d   = len_q;
    ok_d    = ok_q;

    res_valid_o          = 1'b0;
    res_o.kind           = KIND_ABORT;
    res_o.data_byte      = 8'd0;
    res_o.byte_index     = 8'd0;
    res_o.job_id         = task_q;
    res_o.payload_length = len_q;

    if (step_i) begin
      case (phase_q)
        PH_IDLE: begin
          if (byte_i == cfg_i.head_first) begin
            phase_d = PH_HEAD1;
            xor_d   = byte_i;
          end
        end
        PH_HEAD1: begin
          if (byte_i == cfg_i.head_second) begin
            phase_d = PH_TASK_HI;
            xor_d   = xor_q ^ byte_i;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        PH_TASK_HI: begin
          task_d  = {byte_i, 8'd0};
          xor_d   = xor_q ^ byte_i;
          phase_d = PH_TASK_LO;
        end
        PH_TASK_LO: begin
          task_d  = {task_q[15:8], byte_i};
          xor_d   = xor_q ^ byte_i;
          phase_d = PH_LENGTH;
        end
        PH_LENGTH: begin
          len_d   = byte_i;
          left_d  = byte_i;
          count_d = 8'd0;
          xor_d   = xor_q ^ byte_i;
          phase_d = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          res_valid_o = 1'b1;
          if (left_q == 8'd0) begin
            phase_d = PH_IDLE;
          end else begin
            xor_d            = xor_q ^ byte_i;
            left_d           = left_q - 8'd1;
            count_d          = count_q + 8'd1;
            res_o.kind       = KIND_PAYLOAD;
            res_o.data_byte  = byte_i;
            res_o.byte_index = count_q;
            if (left_q == 8'd1) begin
              phase_d = PH_CHECK;
            end
          end
        end
        PH_CHECK: begin
          ok_d    = (byte_i == xor_q);
          phase_d = PH_TAIL1;
        end
        PH_TAIL1: begin
          if (byte_i == cfg_i.tail_first) begin
            phase_d = PH_TAIL2;
          end else begin
            phase_d     = PH_IDLE;
            res_valid_o = 1'b1;
          end
        end
        PH_TAIL2: begin
          phase_d     = PH_IDLE;
          res_valid_o = 1'b1;
          if (byte_i == cfg_i.tail_second) begin
            res_o.kind = ok_q ? KIND_GOOD : KIND_BAD;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      left_q  <= 8'd0;
      count_q <= 8'd0;
      xor_q   <= 8'd0;
      task_q  <= 16'd0;
      len_q   <= 8'd0;
      ok_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      count_q <= count_d;
      xor_q   <= xor_d;
      task_q  <= task_d;
      len_q   <= len_d;
      ok_q    <= ok_d;
    end
  end

endmodule
`default_nettype wire

[rtl/serial_frame_deframer_xor.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// serial_frame_deframer_xor
// Length-prefixed frame parser with XOR checksum over a received byte stream.
// Each item is held in the input register, and its result in the output register.
// Throughput: one item per cycle while out_stall_i does not hold a waiting result.
// Reset clears the parser state and loads the default header and trailer.
// ----------------------------------------------------------------------------
module serial_frame_deframer_xor (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic [7:0]   in_rx_byte_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [1:0]        out_kind_o,
  output logic [7:0]        out_data_byte_o,
  output logic [7:0]        out_byte_index_o,
  output logic [15:0]       out_job_id_o,
  output logic [7:0]        out_payload_length_o,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [7:0]   cfg_data_i
);
  import sfd_pkg::*;

  cfg_t       cfg;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  res_t       out_res_q;
  logic       out_free;
  logic       advance;
  logic       res_valid;
  res_t       res;

  sfd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = advance && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= in_rx_byte_i;
    end
    if (advance && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_kind_o           = out_res_q.kind;
  assign out_data_byte_o      = out_res_q.data_byte;
  assign out_byte_index_o     = out_res_q.byte_index;
  assign out_job_id_o         = out_res_q.job_id;
  assign out_payload_length_o = out_res_q.payload_length;

  a_stall_only_when_blocked: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i)
  ) else $error("Input stalled while the output register could take an item.");

  a_no_data_on_status: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_o != KIND_PAYLOAD)
      |-> (out_data_byte_o == 8'd0 && out_byte_index_o == 8'd0)
  ) else $error("Status item carries payload data or index.");

  a_index_in_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_o == KIND_PAYLOAD)
      |-> (out_byte_index_o < out_payload_length_o)
  ) else $error("Payload index beyond the frame length.");

endmodule
`default_nettype wire
